[rtl/core/cdr_pkg.sv]
// Shared types and codes for the card deque with rotation.
`default_nettype none

package cdr_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_TOP      = 2'd0,
        OP_POP_TOP       = 2'd1,
        OP_BOTTOM_TO_TOP = 2'd2,
        OP_TOP_TO_BOTTOM = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } state_t;

    typedef enum logic {
        RD_HEAD,
        RD_BOTTOM
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_TOP_NEW,
        WR_TOP_MOVED,
        WR_TAIL_MOVED
    } wr_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        ptr_op_t head_op;
        ptr_op_t cnt_op;
        logic    res_load;
        status_t res_status;
        logic    res_pop;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    full;
        logic    single;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/cdr_ctrl.sv]
// Sequencer for the card deque: accept, execute, read back, present the result.
`default_nettype none

module cdr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire cdr_pkg::dp_stat_t stat,
    output cdr_pkg::dp_cmd_t       cmd
);
    import cdr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   need_read;

    // Pop and non-trivial rotations need the stored card first.
    always_comb
    begin
        need_read = 1'b0;
        case (stat.op)
            OP_PUSH_TOP:      need_read = 1'b0;
            OP_POP_TOP:       need_read = !stat.empty;
            OP_BOTTOM_TO_TOP: need_read = !stat.empty && !stat.single;
            OP_TOP_TO_BOTTOM: need_read = !stat.empty && !stat.single;
            default:          need_read = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = need_read ? S_READ : S_OUT;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        cmd            = '0;
        cmd.rd_sel     = RD_HEAD;
        cmd.wr_sel     = WR_TOP_NEW;
        cmd.head_op    = PTR_HOLD;
        cmd.cnt_op     = PTR_HOLD;
        cmd.res_status = ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_PUSH_TOP:
                    begin
                        cmd.res_load = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_TOP_NEW;
                            cmd.head_op = PTR_DEC;
                            cmd.cnt_op  = PTR_INC;
                        end
                    end
                    OP_POP_TOP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                        end
                    end
                    OP_BOTTOM_TO_TOP, OP_TOP_TO_BOTTOM:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else if (stat.single)
                        begin
                            cmd.res_load = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (stat.op == OP_BOTTOM_TO_TOP) ? RD_BOTTOM : RD_HEAD;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.res_load = 1'b1;
                case (stat.op)
                    OP_POP_TOP:
                    begin
                        cmd.res_pop = 1'b1;
                        cmd.head_op = PTR_INC;
                        cmd.cnt_op  = PTR_DEC;
                    end
                    OP_BOTTOM_TO_TOP:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_TOP_MOVED;
                        cmd.head_op = PTR_DEC;
                    end
                    OP_TOP_TO_BOTTOM:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_TAIL_MOVED;
                        cmd.head_op = PTR_INC;
                    end
                    default:
                    begin
                        cmd.res_pop = 1'b0;
                    end
                endcase
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/cdr_dpath.sv]
// Card store, head pointer, count and result registers of the card deque.
`default_nettype none

module cdr_dpath #(
    parameter int DECK_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cdr_pkg::dp_cmd_t        cmd,
    output cdr_pkg::dp_stat_t            stat,
    input  wire logic             [1:0]  opcode,
    input  wire logic signed      [31:0] card_value,
    output logic                  [1:0]  status,
    output logic signed           [31:0] popped_value,
    output logic                  [6:0]  deck_count
);
    import cdr_pkg::*;

    localparam int ADDR_W = (DECK_DEPTH > 1) ? $clog2(DECK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(DECK_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    logic [VALUE_WIDTH-1:0] card_store [DECK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    opcode_t                op_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [ADDR_W-1:0]      head_reg;
    logic [ADDR_W-1:0]      head_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    status_t                status_reg;
    logic [VALUE_WIDTH-1:0] popped_reg;

    logic [ADDR_W-1:0]      head_dec;
    logic [ADDR_W-1:0]      head_inc;
    logic [SUM_W-1:0]       tail_sum;
    logic [SUM_W-1:0]       bottom_sum;
    logic [ADDR_W-1:0]      tail_addr;
    logic [ADDR_W-1:0]      bottom_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    assign head_dec = (head_reg == '0) ? ADDR_W'(DECK_DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DECK_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Both sums stay below twice the depth (the bottom sum while the deck holds a card), so one subtract wraps them.
    assign tail_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign bottom_sum = tail_sum - 1'b1;

    always_comb
    begin
        tail_addr   = ADDR_W'(tail_sum);
        bottom_addr = ADDR_W'(bottom_sum);
        if (tail_sum >= SUM_W'(DECK_DEPTH))
        begin
            tail_addr = ADDR_W'(tail_sum - SUM_W'(DECK_DEPTH));
        end
        if (bottom_sum >= SUM_W'(DECK_DEPTH))
        begin
            bottom_addr = ADDR_W'(bottom_sum - SUM_W'(DECK_DEPTH));
        end
    end

    assign rd_addr = (cmd.rd_sel == RD_BOTTOM) ? bottom_addr : head_reg;

    always_comb
    begin
        wr_addr = head_dec;
        wr_data = value_reg;
        case (cmd.wr_sel)
            WR_TOP_NEW:
            begin
                wr_addr = head_dec;
                wr_data = value_reg;
            end
            WR_TOP_MOVED:
            begin
                wr_addr = head_dec;
                wr_data = rd_data_reg;
            end
            WR_TAIL_MOVED:
            begin
                wr_addr = tail_addr;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = head_dec;
                wr_data = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            card_store[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= card_store[rd_addr];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        case (cmd.head_op)
            PTR_HOLD: head_next = head_reg;
            PTR_INC:  head_next = head_inc;
            PTR_DEC:  head_next = head_dec;
            default:  head_next = head_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        case (cmd.cnt_op)
            PTR_HOLD: count_next = count_reg;
            PTR_INC:  count_next = count_reg + 1'b1;
            PTR_DEC:  count_next = count_reg - 1'b1;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Request word and result word: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode_t'(opcode);
            value_reg <= VALUE_WIDTH'($unsigned(card_value));
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            popped_reg <= cmd.res_pop ? rd_data_reg : '0;
        end
    end

    assign stat.op     = op_reg;
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CNT_W'(DECK_DEPTH));
    assign stat.single = (count_reg == CNT_W'(1));

    assign status       = status_reg;
    assign popped_value = $signed(32'(popped_reg));
    assign deck_count   = 7'(count_reg);

endmodule

`default_nettype wire

[rtl/core/card_deque_rotate.sv]
// Top level of the card deque with push, pop and rotation requests.
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | opcode, card_value
//  out     | output    | out_valid / out_stall| status, popped_value, deck_count
//
// A push or a refused request passes from acceptance through an execute state to
// the result state; pop and real rotations add a read state after execute, for the
// registered read of the card store ahead of the write.
// One request is in flight at a time; in_stall stays high until its result is taken.
// rst_n clears the head pointer and count; the store itself is not cleared.
// out_stall holds the result word unchanged for as long as it is high.
`default_nettype none

module card_deque_rotate #(
    parameter int DECK_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [1:0]  opcode,
    input  wire logic signed [31:0] card_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [1:0]  status,
    output logic signed      [31:0] popped_value,
    output logic             [6:0]  deck_count
);
    import cdr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdr_dpath #(
        .DECK_DEPTH  (DECK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .card_value   (card_value),
        .status       (status),
        .popped_value (popped_value),
        .deck_count   (deck_count)
    );

endmodule

`default_nettype wire
